// File: hdl/wbrf_pkg.sv
// Shared types, codes and constants of the write buffer with read forwarding.
`timescale 1ns / 1ps

package wbrf_pkg;

    // Field widths of a command and of a result
    localparam int ADDR_W  = 8;
    localparam int DATA_W  = 32;
    localparam int SPAN_W  = 8;
    localparam int COUNT_W = 4;

    // Defaults of the top-level parameters
    localparam int BUFFER_DEPTH_DEF = 8;
    localparam int ADDR_BITS_DEF    = 8;

    // Command codes
    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_ERASE = 2'd1,
        OP_READ  = 2'd2,
        OP_CLEAR = 2'd3
    } t_op;

    // Controller states
    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } t_state;

    // One incoming command
    typedef struct packed {
        t_op               op;
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] data;
        logic [SPAN_W-1:0] span;
    } t_cmd;

    // One result
    typedef struct packed {
        logic               hit;
        logic [DATA_W-1:0]  read_value;
        logic [COUNT_W-1:0] count;
        logic               full_res;
        logic               overflow;
    } t_result;

    // One buffered command as held in memory
    typedef struct packed {
        logic              kind_erase;
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] value;
        logic [SPAN_W-1:0] span;
    } t_entry;

endpackage

// File: hdl/wbrf_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module wbrf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: hdl/wbrf_match.sv
// Coverage check of one buffered command against a read address.
`timescale 1ns / 1ps

module wbrf_match
    import wbrf_pkg::*;
(
    input  t_entry            i_entry,
    input  logic [ADDR_W-1:0] i_addr,
    output logic              o_covers
);

    logic              above_base;
    logic [ADDR_W-1:0] offset;

    // Erase covers base <= addr < base + span without wrap; a write covers its address
    assign above_base = (i_addr >= i_entry.addr);
    assign offset     = i_addr - i_entry.addr;

    always_comb begin
        if (i_entry.kind_erase) begin
            o_covers = above_base && (offset < i_entry.span);
        end else begin
            o_covers = (i_addr == i_entry.addr);
        end
    end

endmodule

// File: hdl/wbrf_ctrl.sv
// Command sequencer: fill count, newest-first read scan and result register.
`timescale 1ns / 1ps

module wbrf_ctrl
    import wbrf_pkg::*;
#(
    parameter int BUFFER_DEPTH = BUFFER_DEPTH_DEF,
    parameter int ADDR_BITS    = ADDR_BITS_DEF,
    localparam int IDX_W       = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    input  t_cmd             i_cmd,
    output logic             busy,
    output logic             o_wr_en,
    output logic [IDX_W-1:0] o_wr_idx,
    output t_entry           o_wr_entry,
    output logic             o_rd_en,
    output logic [IDX_W-1:0] o_rd_idx,
    output logic [ADDR_W-1:0] o_scan_addr,
    input  logic             i_covers,
    input  t_entry           i_rd_entry,
    output logic             o_res_valid,
    output t_result          o_result
);

    localparam int CNT_W = $clog2(BUFFER_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(BUFFER_DEPTH);
    localparam logic [ADDR_W-1:0] ADDR_MASK =
        (ADDR_BITS >= ADDR_W) ? {ADDR_W{1'b1}} : ADDR_W'((64'd1 << ADDR_BITS) - 64'd1);

    t_state            r_state, n_state;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [IDX_W-1:0]  r_idx, n_idx;
    logic [ADDR_W-1:0] r_addr, n_addr;
    t_result           r_result, n_result;
    logic              r_done, n_done;

    logic              accept;
    logic [CNT_W-1:0]  cnt_m1;
    logic [ADDR_W-1:0] addr_m;

    assign accept = start && (r_state == ST_IDLE);
    assign busy   = (r_state != ST_IDLE);
    assign cnt_m1 = r_count - CNT_W'(1);
    assign addr_m = i_cmd.addr & ADDR_MASK;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept && (i_cmd.op == OP_READ) && (r_count != '0)) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (i_covers || (r_idx == '0)) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Memory access, count update and result
    always_comb begin
        n_count  = r_count;
        n_idx    = r_idx;
        n_addr   = r_addr;
        n_result = r_result;
        n_done   = 1'b0;
        o_wr_en  = 1'b0;
        o_wr_idx = r_count[IDX_W-1:0];
        o_rd_en  = 1'b0;
        o_rd_idx = cnt_m1[IDX_W-1:0];

        // Build the entry to append; unused fields are stored as zero
        o_wr_entry.kind_erase = (i_cmd.op == OP_ERASE);
        o_wr_entry.addr       = addr_m;
        o_wr_entry.value      = (i_cmd.op == OP_WRITE) ? i_cmd.data : '0;
        o_wr_entry.span       = (i_cmd.op == OP_ERASE) ? i_cmd.span : '0;

        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_done              = 1'b1;
                    n_result.hit        = 1'b0;
                    n_result.read_value = '0;
                    n_result.overflow   = 1'b0;
                    case (i_cmd.op)
                        OP_WRITE, OP_ERASE: begin
                            if (r_count == DEPTH_C) begin
                                n_result.overflow = 1'b1;
                            end else begin
                                o_wr_en = 1'b1;
                                n_count = r_count + CNT_W'(1);
                            end
                        end
                        OP_READ: begin
                            // Start the scan at the newest entry
                            if (r_count != '0) begin
                                n_done  = 1'b0;
                                o_rd_en = 1'b1;
                                n_idx   = cnt_m1[IDX_W-1:0];
                                n_addr  = addr_m;
                            end
                        end
                        OP_CLEAR: begin
                            n_count = '0;
                        end
                        default: begin
                            n_count = r_count;
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                if (i_covers) begin
                    n_done              = 1'b1;
                    n_result.hit        = 1'b1;
                    n_result.read_value = i_rd_entry.kind_erase ? '0 : i_rd_entry.value;
                    n_result.overflow   = 1'b0;
                end else if (r_idx == '0) begin
                    n_done              = 1'b1;
                    n_result.hit        = 1'b0;
                    n_result.read_value = '0;
                    n_result.overflow   = 1'b0;
                end else begin
                    // Advance to the next older entry
                    o_rd_en  = 1'b1;
                    o_rd_idx = r_idx - IDX_W'(1);
                    n_idx    = r_idx - IDX_W'(1);
                end
            end
            default: begin
                n_done = 1'b0;
            end
        endcase

        if (n_done) begin
            n_result.count    = COUNT_W'(n_count);
            n_result.full_res = (n_count == DEPTH_C);
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_done  <= n_done;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_idx    <= n_idx;
        r_addr   <= n_addr;
        r_result <= n_result;
    end

    assign o_scan_addr = r_addr;
    assign o_res_valid = r_done;
    assign o_result    = r_result;

    // Fill count stays within the buffer
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= DEPTH_C)
        else $error("fill count exceeds buffer depth");

    // No append lands in memory while a scan is reading it
    a_no_write_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> !o_wr_en)
        else $error("memory write during read scan");

    // Overflow is only reported with a full buffer
    a_overflow_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_done && r_result.overflow) |-> (r_count == DEPTH_C))
        else $error("overflow reported with room left");

    // A hit only comes out of a scan
    a_hit_from_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_done && r_result.hit) |-> ($past(r_state) == ST_SCAN))
        else $error("hit reported without a scan");

    // A read of a non-empty buffer holds the block busy next cycle
    a_read_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_cmd.op == OP_READ) && (r_count != '0)) |=> busy)
        else $error("read scan did not start");

endmodule

// File: hdl/write_buffer_read_forwarding.sv
// Top level of the pending-command buffer with newest-first read forwarding.
//
// A command is taken when start is high and busy is low. Writes, erases and clears
// finish without raising busy: their result strobes on o_res_valid the cycle after
// the transfer, and the next command may be taken in that same cycle. A read scans
// the buffered commands newest first through the one read port of the entry memory,
// one entry per cycle: busy stays high while entries are examined (1 to BUFFER_DEPTH
// of them), and the result strobes the cycle after the last. A read of an empty
// buffer does not raise busy and answers like a write. The receiver cannot stall:
// each result is valid for exactly one cycle. The entry memory is not cleared at
// reset; only entries below the fill count are ever read.
`timescale 1ns / 1ps

module write_buffer_read_forwarding
    import wbrf_pkg::*;
#(
    parameter int BUFFER_DEPTH = BUFFER_DEPTH_DEF,
    parameter int ADDR_BITS    = ADDR_BITS_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    input  t_cmd    i_cmd,
    output logic    busy,
    output logic    o_res_valid,
    output t_result o_result
);

    localparam int IDX_W = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;

    logic              wr_en;
    logic [IDX_W-1:0]  wr_idx;
    t_entry            wr_entry;
    logic              rd_en;
    logic [IDX_W-1:0]  rd_idx;
    t_entry            rd_entry;
    logic [ADDR_W-1:0] scan_addr;
    logic              covers;

    // Sequencer
    wbrf_ctrl #(
        .BUFFER_DEPTH (BUFFER_DEPTH),
        .ADDR_BITS    (ADDR_BITS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .i_cmd       (i_cmd),
        .busy        (busy),
        .o_wr_en     (wr_en),
        .o_wr_idx    (wr_idx),
        .o_wr_entry  (wr_entry),
        .o_rd_en     (rd_en),
        .o_rd_idx    (rd_idx),
        .o_scan_addr (scan_addr),
        .i_covers    (covers),
        .i_rd_entry  (rd_entry),
        .o_res_valid (o_res_valid),
        .o_result    (o_result)
    );

    // Entry memory
    wbrf_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (BUFFER_DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_idx),
        .i_wr_data (wr_entry),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_idx),
        .o_rd_data (rd_entry)
    );

    // Coverage check of the entry just read
    wbrf_match u_match (
        .i_entry  (rd_entry),
        .i_addr   (scan_addr),
        .o_covers (covers)
    );

endmodule

// File: test/wbrf_checker.sv
// Checker that predicts and compares every result of the write buffer with read forwarding.
`timescale 1ns / 1ps

module wbrf_checker
    import wbrf_pkg::*;
#(
    parameter int BUFFER_DEPTH = BUFFER_DEPTH_DEF,
    parameter int ADDR_BITS    = ADDR_BITS_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    input  t_cmd    i_cmd,
    input  logic    busy,
    input  logic    i_res_valid,
    input  t_result i_result,
    output int      o_fail_count,
    output int      o_pending
);

    localparam int MAX_REPORTS = 10;

    // Shadow copy of the buffered commands
    t_entry  held_cmds [BUFFER_DEPTH];
    int      held_count;

    t_result expected_results [$];
    t_result oldest_result;
    int      mismatches;

    initial begin
        held_count   = 0;
        mismatches   = 0;
        o_fail_count = 0;
        o_pending    = 0;
    end

    // True when a held command answers a read of the given address
    function automatic bit covers_addr(t_entry e, int a);
        int base;
        base = int'(e.addr);
        if (e.kind_erase) begin
            return (a >= base) && ((a - base) < int'(e.span));
        end
        return a == base;
    endfunction

    // Apply one command to the shadow buffer and work out its result
    function automatic t_result apply_cmd(t_cmd c);
        t_result r;
        int      a;
        int      k;
        bit      found;
        r     = '0;
        a     = int'(c.addr) & ((1 << ADDR_BITS) - 1);
        found = 1'b0;
        case (c.op)
            OP_WRITE, OP_ERASE: begin
                if (held_count >= BUFFER_DEPTH) begin
                    r.overflow = 1'b1;
                end else begin
                    held_cmds[held_count].kind_erase = (c.op == OP_ERASE);
                    held_cmds[held_count].addr       = ADDR_W'(a);
                    held_cmds[held_count].value      = (c.op == OP_WRITE) ? c.data : '0;
                    held_cmds[held_count].span       = (c.op == OP_ERASE) ? c.span : '0;
                    held_count++;
                end
            end
            OP_READ: begin
                // Scan newest first, stop at the first covering command
                for (k = held_count - 1; k >= 0; k--) begin
                    if (!found && covers_addr(held_cmds[k], a)) begin
                        found        = 1'b1;
                        r.hit        = 1'b1;
                        r.read_value = held_cmds[k].kind_erase ? '0 : held_cmds[k].value;
                    end
                end
            end
            default: begin
                held_count = 0;
            end
        endcase
        r.count    = COUNT_W'(held_count);
        r.full_res = (held_count == BUFFER_DEPTH);
        return r;
    endfunction

    task automatic report_mismatch(string what, t_result want, t_result got);
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
            $display("%0t %s: expected hit=%0d value=%h count=%0d full=%0d ovf=%0d",
                     $time, what, want.hit, want.read_value, want.count,
                     want.full_res, want.overflow);
            $display("%0t %s: got      hit=%0d value=%h count=%0d full=%0d ovf=%0d",
                     $time, what, got.hit, got.read_value, got.count,
                     got.full_res, got.overflow);
        end
    endtask

    // Compare the result that ends this cycle, then queue the new transfer
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            held_count = 0;
            expected_results.delete();
        end else begin
            if (i_res_valid) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected result", '0, i_result);
                end else begin
                    oldest_result = expected_results.pop_front();
                    if (i_result !== oldest_result) begin
                        report_mismatch("result mismatch", oldest_result, i_result);
                    end
                end
            end
            if (start && !busy) begin
                expected_results.insert(expected_results.size(), apply_cmd(i_cmd));
            end
        end
        o_fail_count <= mismatches;
        o_pending    <= expected_results.size();
    end

endmodule

// File: test/testbench.sv
// Top of the testbench: clock, reset, command stimulus, watchdog and verdict.
`timescale 1ns / 1ps

module testbench;
    import wbrf_pkg::*;

    localparam int CLK_HALF       = 5;
    localparam int RESET_CYCLES   = 5;
    localparam int PHASE_ITEMS    = 410;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int DRAIN_CYCLES   = 20;

    logic    i_clk   = 1'b0;
    logic    i_rst_n = 1'b0;
    logic    start   = 1'b0;
    t_cmd    i_cmd   = '0;
    logic    busy;
    logic    o_res_valid;
    t_result o_result;

    int      fail_count;
    int      pending;
    int      gap_pct;
    int      stall_cycles = 0;

    write_buffer_read_forwarding dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .i_cmd       (i_cmd),
        .busy        (busy),
        .o_res_valid (o_res_valid),
        .o_result    (o_result)
    );

    wbrf_checker checker_inst (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .i_cmd        (i_cmd),
        .busy         (busy),
        .i_res_valid  (o_res_valid),
        .i_result     (o_result),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    // End the run when nothing has moved for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_res_valid) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    function automatic t_cmd make_cmd(t_op op, int addr, logic [DATA_W-1:0] data, int span);
        t_cmd c;
        c.op   = op;
        c.addr = ADDR_W'(addr);
        c.data = data;
        c.span = SPAN_W'(span);
        return c;
    endfunction

    // Mostly hot addresses at both ends of the space so reads hit often
    function automatic t_cmd random_cmd();
        t_cmd c;
        int   pick;
        pick = $urandom_range(99);
        if (pick < 25) begin
            c.op = OP_WRITE;
        end else if (pick < 45) begin
            c.op = OP_ERASE;
        end else if (pick < 93) begin
            c.op = OP_READ;
        end else begin
            c.op = OP_CLEAR;
        end
        if ($urandom_range(99) < 65) begin
            pick   = $urandom_range(15);
            c.addr = ADDR_W'((pick >= 8) ? pick + 240 : pick);
        end else begin
            c.addr = ADDR_W'($urandom);
        end
        c.data = $urandom;
        c.span = ($urandom_range(1) == 0) ? SPAN_W'($urandom_range(12)) : SPAN_W'($urandom);
        return c;
    endfunction

    // Hold the command until it transfers; return at the following falling edge
    task automatic issue_cmd(input t_cmd c);
        while ($urandom_range(99) < gap_pct) begin
            start <= 1'b0;
            i_cmd <= t_cmd'({$urandom, $urandom});
            @(negedge i_clk);
        end
        start <= 1'b1;
        i_cmd <= c;
        do @(posedge i_clk); while (busy);
        @(negedge i_clk);
    endtask

    initial begin
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        gap_pct = 13;

        // Empty buffer: read miss and a clear with nothing held
        issue_cmd(make_cmd(OP_READ,  8'h00, 32'h0, 0));
        issue_cmd(make_cmd(OP_CLEAR, 8'hff, 32'hffffffff, 255));
        // Extreme writes; span of a write is dropped
        issue_cmd(make_cmd(OP_WRITE, 8'h00, 32'h00000000, 255));
        issue_cmd(make_cmd(OP_WRITE, 8'hff, 32'hffffffff, 0));
        // Zero-span erase is held but covers nothing
        issue_cmd(make_cmd(OP_ERASE, 8'h10, 32'h0, 0));
        issue_cmd(make_cmd(OP_READ,  8'h10, 32'h0, 0));
        // Erase running past the top of the address space
        issue_cmd(make_cmd(OP_ERASE, 8'hf0, 32'h0, 255));
        issue_cmd(make_cmd(OP_READ,  8'hff, 32'h0, 0));
        issue_cmd(make_cmd(OP_READ,  8'h00, 32'h0, 0));
        issue_cmd(make_cmd(OP_WRITE, 8'h20, 32'ha5a5a5a5, 0));
        // Erase data is dropped
        issue_cmd(make_cmd(OP_ERASE, 8'h00, 32'hffffffff, 255));
        issue_cmd(make_cmd(OP_WRITE, 8'h55, 32'hdeadbeef, 0));
        issue_cmd(make_cmd(OP_WRITE, 8'h20, 32'h5a5a5a5a, 0));
        // Full: both kinds of append are refused
        issue_cmd(make_cmd(OP_WRITE, 8'h33, 32'h12345678, 0));
        issue_cmd(make_cmd(OP_ERASE, 8'h33, 32'h0, 4));
        // Newest write wins, erase forwards zero, highest address
        issue_cmd(make_cmd(OP_READ,  8'h20, 32'h0, 0));
        issue_cmd(make_cmd(OP_READ,  8'h21, 32'h0, 0));
        issue_cmd(make_cmd(OP_READ,  8'hff, 32'h0, 0));
        issue_cmd(make_cmd(OP_CLEAR, 8'h00, 32'h0, 0));
        issue_cmd(make_cmd(OP_READ,  8'h20, 32'h0, 0));
        issue_cmd(make_cmd(OP_WRITE, 8'h80, 32'h87654321, 0));
        issue_cmd(make_cmd(OP_READ,  8'h80, 32'h0, 0));
        issue_cmd(make_cmd(OP_READ,  8'h7f, 32'h0, 0));

        // Random traffic under three gap settings
        repeat (PHASE_ITEMS) issue_cmd(random_cmd());
        gap_pct = 76;
        repeat (PHASE_ITEMS) issue_cmd(random_cmd());
        gap_pct = 0;
        repeat (PHASE_ITEMS) issue_cmd(random_cmd());

        // Drain outstanding results, then allow for a stray late strobe
        start <= 1'b0;
        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0 && pending == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// File: filelist.f
hdl/wbrf_pkg.sv
hdl/wbrf_ram.sv
hdl/wbrf_match.sv
hdl/wbrf_ctrl.sv
hdl/write_buffer_read_forwarding.sv
test/wbrf_checker.sv
test/testbench.sv
